>>> rtl/fdig_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the four-direction image gradient block.
package fdig_pkg;

  typedef logic [3:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 4'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 4'd1;

  localparam int FIFO_DEPTH = 8;

  typedef struct packed {
    logic valid;
    logic first_col;
    logic last_col;
    logic flushing;
    logic top_from_newer;
    logic emit;
  } fdig_ctl_t;

endpackage

>>> rtl/four_direction_image_gradient_top.sv
`timescale 1ns / 1ps
// Top level of the four-direction central-difference image gradient block.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | in_pixel, in_flush
//  out_    | output    | out_valid / out_stall | out_grad_x/y/45/135, out_frame_end, out_run_end
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle sustained while in_stall is low; a result passes the line
// memory read register and then the result queue before it leaves.
// The last column of each row after row 0 yields two results, drained by the 8-entry queue.
// rst_n clears position counters, registers to 1024 x 480, and the queue.
// in_stall rises only when the queue lacks room for the items in flight.
// A write to the width or height register restarts the frame at row 0, column 0.
module four_direction_image_gradient_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [PIXEL_BITS-1:0]       in_pixel,
  input  logic                        in_flush,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [PIXEL_BITS:0]  out_grad_x,
  output logic signed [PIXEL_BITS:0]  out_grad_y,
  output logic signed [PIXEL_BITS:0]  out_grad_45,
  output logic signed [PIXEL_BITS:0]  out_grad_135,
  output logic                        out_frame_end,
  output logic                        out_run_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  fdig_pkg::cfg_idx_t          cfg_index,
  input  logic [15:0]                 cfg_data
);

  import fdig_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int EW      = 4 * (PIXEL_BITS + 1) + 2;
  localparam int QCW     = $clog2(FIFO_DEPTH + 1);
  localparam int RESET_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [AW-1:0]         col_r, col_nxt;
  logic [15:0]           row_r, row_nxt;
  logic [AW-1:0]         wlast_r, wlast_nxt;
  logic [15:0]           h_r, h_nxt;
  fdig_ctl_t             ctl_r, ctl_nxt;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [AW-1:0]         s1_addr_r;

  logic                  in_acc;
  logic                  cfg_wr;
  logic [31:0]           wsat;
  logic [PIXEL_BITS-1:0] rd_older, rd_newer;
  logic                  push0, push1;
  logic [EW-1:0]         res0, res1, head;
  logic [QCW-1:0]        q_count;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_acc    = in_valid & ~in_stall;

  // reserve room for the item in the window stage and the one entering
  assign in_stall = (32'(q_count) + (ctl_r.valid ? 32'd4 : 32'd2)) > 32'(FIFO_DEPTH);

  always_comb begin
    if (cfg_data[10:0] < 11'd3) begin
      wsat = 32'd3;
    end else if (32'(cfg_data[10:0]) > 32'(MAX_WIDTH)) begin
      wsat = 32'(MAX_WIDTH);
    end else begin
      wsat = 32'(cfg_data[10:0]);
    end
  end

  always_comb begin
    wlast_nxt = wlast_r;
    h_nxt     = h_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (cfg_wr && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT)) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        wlast_nxt = AW'(wsat - 32'd1);
      end else begin
        h_nxt = (cfg_data < 16'd3) ? 16'd3 : cfg_data;
      end
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_r == wlast_r) begin
        col_nxt = '0;
        row_nxt = (row_r == h_r) ? 16'd0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_comb begin
    ctl_nxt.valid          = in_acc;
    ctl_nxt.first_col      = (col_r == '0);
    ctl_nxt.last_col       = (col_r == wlast_r);
    ctl_nxt.flushing       = (row_r == h_r);
    ctl_nxt.top_from_newer = (row_r <= 16'd1);
    ctl_nxt.emit           = (row_r != 16'd0) && (col_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      wlast_r <= AW'(RESET_W - 1);
      h_r     <= 16'd480;
      ctl_r   <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      wlast_r <= wlast_nxt;
      h_r     <= h_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_pixel;
      s1_addr_r <= col_r;
    end
  end

  fdig_line_mem #(
    .DEPTH      (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_mem (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (col_r),
    .rd_older (rd_older),
    .rd_newer (rd_newer),
    .wr_en    (ctl_r.valid),
    .wr_addr  (s1_addr_r),
    .wr_pixel (s1_pix_r)
  );

  fdig_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk   (clk),
    .ctl   (ctl_r),
    .pixel (s1_pix_r),
    .older (rd_older),
    .newer (rd_newer),
    .push0 (push0),
    .push1 (push1),
    .res0  (res0),
    .res1  (res1)
  );

  fdig_out_fifo #(
    .ENTRY_BITS (EW)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push0 (push0),
    .push1 (push1),
    .data0 (res0),
    .data1 (res1),
    .pop   (out_valid & ~out_stall),
    .head  (head),
    .count (q_count)
  );

  assign out_valid = (q_count != '0);
  assign {out_grad_x, out_grad_y, out_grad_45, out_grad_135,
          out_frame_end, out_run_end} = head;

`ifndef SYNTHESIS
  a_no_mem_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ctl_r.valid && !$past(cfg_wr)) |-> (col_r != s1_addr_r))
    else $error("line memory read and write hit the same column");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast_r)
    else $error("column position past row end");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= h_r)
    else $error("row position past flush row");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_run_end)
    else $error("frame end on a non-final result");
`endif

endmodule

>>> rtl/fdig_line_mem.sv
`timescale 1ns / 1ps
// Two-row line store: one synchronous memory holding {older, newer} per column.
module fdig_line_mem #(
  parameter int DEPTH      = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [PIXEL_BITS-1:0]        rd_older,
  output logic [PIXEL_BITS-1:0]        rd_newer,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [PIXEL_BITS-1:0]        wr_pixel
);

  logic [2*PIXEL_BITS-1:0] mem_r [DEPTH];
  logic [2*PIXEL_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // age the column: newer moves to older, incoming pixel becomes newer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {rd_data_r[PIXEL_BITS-1:0], wr_pixel};
    end
  end

  assign rd_older = rd_data_r[2*PIXEL_BITS-1:PIXEL_BITS];
  assign rd_newer = rd_data_r[PIXEL_BITS-1:0];

endmodule

>>> rtl/fdig_window.sv
`timescale 1ns / 1ps
// 3x3 window register and the four central differences for up to two results.
module fdig_window #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  fdig_pkg::fdig_ctl_t          ctl,
  input  logic [PIXEL_BITS-1:0]        pixel,
  input  logic [PIXEL_BITS-1:0]        older,
  input  logic [PIXEL_BITS-1:0]        newer,
  output logic                         push0,
  output logic                         push1,
  output logic [4*(PIXEL_BITS+1)+1:0]  res0,
  output logic [4*(PIXEL_BITS+1)+1:0]  res1
);

  import fdig_pkg::*;

  logic [PIXEL_BITS-1:0] win_r   [9];
  logic [PIXEL_BITS-1:0] win_nxt [9];
  logic [PIXEL_BITS-1:0] col     [3];

  function automatic logic [PIXEL_BITS:0] sub(input logic [PIXEL_BITS-1:0] a,
                                              input logic [PIXEL_BITS-1:0] b);
    sub = {1'b0, a} - {1'b0, b};
  endfunction

  assign col[0] = ctl.top_from_newer ? newer : older;
  assign col[1] = newer;
  assign col[2] = ctl.flushing ? newer : pixel;

  always_comb begin
    win_nxt = win_r;
    if (ctl.valid) begin
      for (int i = 0; i < 3; i++) begin
        if (ctl.first_col) begin
          win_nxt[i]     = col[i];
          win_nxt[3 + i] = col[i];
          win_nxt[6 + i] = col[i];
        end else begin
          win_nxt[i]     = win_r[3 + i];
          win_nxt[3 + i] = win_r[6 + i];
          win_nxt[6 + i] = col[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign push0 = ctl.valid & ctl.emit;
  assign push1 = push0 & ctl.last_col;

  assign res0 = {sub(win_nxt[7], win_nxt[1]), sub(win_nxt[5], win_nxt[3]),
                 sub(win_nxt[2], win_nxt[6]), sub(win_nxt[8], win_nxt[0]),
                 1'b0, ~ctl.last_col};

  // right edge: right column clamps onto the centre column
  assign res1 = {sub(win_nxt[7], win_nxt[4]), sub(win_nxt[8], win_nxt[6]),
                 sub(win_nxt[5], win_nxt[6]), sub(win_nxt[8], win_nxt[3]),
                 ctl.flushing, 1'b1};

endmodule

>>> rtl/fdig_out_fifo.sv
`timescale 1ns / 1ps
// Result queue taking up to two entries per cycle and delivering one per cycle while pop is high.
module fdig_out_fifo #(
  parameter int ENTRY_BITS = 70
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        push0,
  input  logic                                        push1,
  input  logic [ENTRY_BITS-1:0]                       data0,
  input  logic [ENTRY_BITS-1:0]                       data1,
  input  logic                                        pop,
  output logic [ENTRY_BITS-1:0]                       head,
  output logic [$clog2(fdig_pkg::FIFO_DEPTH+1)-1:0]   count
);

  import fdig_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [ENTRY_BITS-1:0] slot_r [FIFO_DEPTH];
  logic [PW-1:0]         wp_r, wp_nxt;
  logic [PW-1:0]         rp_r, rp_nxt;
  logic [CW-1:0]         count_r, count_nxt;

  always_comb begin
    wp_nxt    = wp_r + PW'(push0) + PW'(push1);
    rp_nxt    = rp_r + PW'(pop);
    count_nxt = count_r + CW'(push0) + CW'(push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      slot_r[wp_r] <= data0;
    end
    if (push1) begin
      slot_r[wp_r + PW'(1)] <= data1;
    end
  end

  assign head  = slot_r[rp_r];
  assign count = count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= FIFO_DEPTH)
    else $error("result queue count out of range");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0)
    else $error("second push without first");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(count_r) + 32'(push0) + 32'(push1)) <= (FIFO_DEPTH + 32'(pop)))
    else $error("result queue overflow");
`endif

endmodule
